>>> hdl/row_run_line_removal_unit_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef ROW_RUN_LINE_REMOVAL_UNIT_DEFINES_SVH
`define ROW_RUN_LINE_REMOVAL_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRLR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RRLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/rrlr_pkg.sv
package rrlr_pkg;

    // Width of every configuration register.
    localparam int CFG_W = 12;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_ROW_WIDTH   = 2'd0;
    localparam logic [1:0] REG_RUN_THRESH  = 2'd1;
    localparam logic [1:0] REG_PROF_THRESH = 2'd2;

    // Register reset values.
    localparam logic [CFG_W-1:0] ROW_WIDTH_RST   = 12'd2048;
    localparam logic [CFG_W-1:0] RUN_THRESH_RST  = 12'd1331;
    localparam logic [CFG_W-1:0] PROF_THRESH_RST = 12'd1638;

    // The set-pixel count saturates at this value.
    localparam logic [CFG_W-1:0] SET_COUNT_MAX = 12'hFFF;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_BACK_RD,
        ST_BACK_WR,
        ST_BACK_FILL,
        ST_FINISH,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } t_state;

endpackage

>>> hdl/row_run_line_removal_unit.sv
// Horizontal line removal on one row of a binary image.
// Requests: a word of WORD_BITS pixels is taken at a rising edge with start high and
// busy low; bit k of word w is column w*WORD_BITS+k, and 1 is ink. Words arrive in
// row order. After the word that reaches the row width, the cleaned row is sent
// back one word per result, each shown for one cycle with o_result_valid high,
// o_last_of_row marking the final word. The receiver cannot stall results.
// Each word is scanned by a single pixel engine, one pixel per clock while no
// back-fill holds the scan. Words are taken only while busy is low, so a word is
// not taken before the scan of the previous one ends. At the row end a finish
// state settles the row test. A long run that closes after crossing a word boundary
// stalls the scan for a back-fill of the clear-mask memory: the run's first word is
// read and rewritten, then each word strictly between the run's first word and the
// word where it closes is written in turn. Emission reads each row word through a
// registered memory read, then loads the output register; the last result shows as
// busy falls. Reset clears the sequencer, counters and control registers to their
// defaults; the row and mask memories need no clearing pass, since each entry is
// written before it is read within a row. Configuration through the APB port is to
// be done while busy is low; the user is bound by this, the block does not enforce it.
module row_run_line_removal_unit #(
    parameter int MAX_ROW_PIXELS = 2048,
    parameter int WORD_BITS      = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Request channel.
    input  logic                                start,
    output logic                                busy,
    input  logic [WORD_BITS-1:0]                i_pixel_word,
    // Result channel.
    output logic                                o_result_valid,
    output logic [WORD_BITS-1:0]                o_cleaned_word,
    output logic                                o_last_of_row,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rrlr_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rrlr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rrlr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import rrlr_pkg::*;

    localparam int ROW_WORDS = (MAX_ROW_PIXELS + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W    = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
    localparam int BW        = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int KW        = $clog2(WORD_BITS + 1);
    localparam int CW_RAW    = $clog2(MAX_ROW_PIXELS + 2 * WORD_BITS + 1);
    localparam int CW        = (CW_RAW > CFG_W) ? CW_RAW : CFG_W;
    localparam int RL_W      = $clog2(MAX_ROW_PIXELS + 1);
    localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

    // Control registers.
    t_state                 r_state, n_state;
    logic [CFG_W-1:0]       r_row_width, r_run_thresh, r_prof_thresh;
    logic [WIDX_W-1:0]      r_widx, n_widx;
    logic [CW-1:0]          r_base, n_base;
    logic [KW-1:0]          r_k, n_k;
    logic [RL_W-1:0]        r_run_len, n_run_len;
    logic [CFG_W-1:0]       r_set_count, n_set_count;
    logic                   r_final, n_final;
    logic                   r_out_valid, n_out_valid;

    // Payload registers.
    logic [WORD_BITS-1:0]   r_word, n_word;
    logic [WORD_BITS-1:0]   r_cur_mask, n_cur_mask;
    logic [WIDX_W-1:0]      r_run_sw, n_run_sw;
    logic [BW-1:0]          r_run_sb, n_run_sb;
    logic [WIDX_W-1:0]      r_bidx, n_bidx;
    logic [WIDX_W-1:0]      r_eidx, n_eidx;
    logic [CW-1:0]          r_ebase, n_ebase;
    logic                   r_whole, n_whole;
    logic [WORD_BITS-1:0]   r_mask_rd, r_row_rd;
    logic [WORD_BITS-1:0]   r_out_word, n_out_word;
    logic                   r_out_last, n_out_last;

    // Row and clear-mask memories.
    logic [WORD_BITS-1:0]   r_row_mem  [ROW_WORDS];
    logic [WORD_BITS-1:0]   r_mask_mem [ROW_WORDS];

    // Mask memory port controls.
    logic                   mw_en;
    logic [WIDX_W-1:0]      mw_addr;
    logic [WORD_BITS-1:0]   mw_data;
    logic                   mr_en;
    logic [WIDX_W-1:0]      mr_addr;

    // Shared pixel engine signals.
    logic [CW-1:0]          eff_width;
    logic [CW-1:0]          col;
    logic                   at_end;
    logic                   word_last;
    logic                   pix;
    logic                   run_long;
    logic                   same_word;
    logic [KW-1:0]          range_lo;
    logic [WORD_BITS-1:0]   range_mask;
    logic [CW-1:0]          left;
    logic [WORD_BITS-1:0]   valid_mask;
    logic                   emit_last;
    logic                   cfg_wr;
    logic [1:0]             cfg_idx;

    // Effective row width: zero counts as one, large values saturate.
    always_comb begin
        if (r_row_width == '0) begin
            eff_width = CW'(1);
        end else if (CW'(r_row_width) > CW'(MAX_ROW_PIXELS)) begin
            eff_width = CW'(MAX_ROW_PIXELS);
        end else begin
            eff_width = CW'(r_row_width);
        end
    end

    // Scan position, end-of-word and end-of-row tests.
    assign col       = r_base + CW'(r_k);
    assign at_end    = (r_k == KW'(WORD_BITS)) || (col >= eff_width);
    assign word_last = (r_base + CW'(WORD_BITS)) >= eff_width;
    assign pix       = r_word[r_k[BW-1:0]];
    assign run_long  = CW'(r_run_len) > CW'(r_run_thresh);
    assign same_word = (r_run_sw == r_widx);

    // Bits of the current word covered by the closing run.
    assign range_lo   = same_word ? KW'(r_run_sb) : '0;
    assign range_mask = (ONES << range_lo) & ~(ONES << r_k);

    // Pixels past the row width are forced to zero on output.
    assign left       = eff_width - r_ebase;
    assign valid_mask = (left >= CW'(WORD_BITS)) ? ONES : ~(ONES << left[KW-1:0]);
    assign emit_last  = (r_ebase + CW'(WORD_BITS)) >= eff_width;

    // Configuration port.
    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (cfg_idx)
            REG_ROW_WIDTH:   prdata = APB_DATA_W'(r_row_width);
            REG_RUN_THRESH:  prdata = APB_DATA_W'(r_run_thresh);
            REG_PROF_THRESH: prdata = APB_DATA_W'(r_prof_thresh);
            default:         prdata = '0;
        endcase
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!at_end) begin
                    if (!pix && r_run_len != '0 && run_long && !same_word) begin
                        n_state = ST_BACK_RD;
                    end
                end else if (!word_last) begin
                    n_state = ST_IDLE;
                end else if (r_run_len != '0 && run_long && !same_word) begin
                    n_state = ST_BACK_RD;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_BACK_RD: begin
                n_state = ST_BACK_WR;
            end
            ST_BACK_WR: begin
                if ({1'b0, r_run_sw} + 1'b1 != {1'b0, r_widx}) begin
                    n_state = ST_BACK_FILL;
                end else begin
                    n_state = r_final ? ST_FINISH : ST_SCAN;
                end
            end
            ST_BACK_FILL: begin
                if ({1'b0, r_bidx} + 1'b1 == {1'b0, r_widx}) begin
                    n_state = r_final ? ST_FINISH : ST_SCAN;
                end
            end
            ST_FINISH: begin
                n_state = ST_EMIT_RD;
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                n_state = emit_last ? ST_IDLE : ST_EMIT_RD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory controls for each state.
    always_comb begin
        n_widx      = r_widx;
        n_base      = r_base;
        n_k         = r_k;
        n_run_len   = r_run_len;
        n_set_count = r_set_count;
        n_final     = r_final;
        n_out_valid = 1'b0;
        n_word      = r_word;
        n_cur_mask  = r_cur_mask;
        n_run_sw    = r_run_sw;
        n_run_sb    = r_run_sb;
        n_bidx      = r_bidx;
        n_eidx      = r_eidx;
        n_ebase     = r_ebase;
        n_whole     = r_whole;
        n_out_word  = r_out_word;
        n_out_last  = r_out_last;
        mw_en       = 1'b0;
        mw_addr     = r_widx;
        mw_data     = r_cur_mask;
        mr_en       = 1'b0;
        mr_addr     = r_run_sw;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_word     = i_pixel_word;
                    n_cur_mask = '0;
                    n_k        = '0;
                end
            end
            ST_SCAN: begin
                if (!at_end) begin
                    // One pixel per clock through the run tracker, unless a back-fill holds the scan.
                    n_k = r_k + 1'b1;
                    if (pix) begin
                        if (r_set_count != SET_COUNT_MAX) begin
                            n_set_count = r_set_count + 1'b1;
                        end
                        if (r_run_len == '0) begin
                            n_run_sw = r_widx;
                            n_run_sb = r_k[BW-1:0];
                        end
                        n_run_len = r_run_len + 1'b1;
                    end else if (r_run_len != '0) begin
                        if (run_long) begin
                            n_cur_mask = r_cur_mask | range_mask;
                            n_final    = 1'b0;
                        end
                        n_run_len = '0;
                    end
                end else if (!word_last) begin
                    // Word done; the open run carries into the next word.
                    mw_en   = 1'b1;
                    n_widx  = r_widx + 1'b1;
                    n_base  = r_base + CW'(WORD_BITS);
                end else begin
                    // Row end closes any open run.
                    if (r_run_len != '0 && run_long) begin
                        n_cur_mask = r_cur_mask | range_mask;
                        n_final    = 1'b1;
                    end
                    n_run_len = '0;
                end
            end
            ST_BACK_RD: begin
                mr_en   = 1'b1;
                mr_addr = r_run_sw;
            end
            ST_BACK_WR: begin
                // The run's first word keeps its earlier marks below the run.
                mw_en   = 1'b1;
                mw_addr = r_run_sw;
                mw_data = r_mask_rd | (ONES << r_run_sb);
                n_bidx  = r_run_sw + 1'b1;
            end
            ST_BACK_FILL: begin
                // Words fully inside the run are cleared entirely.
                mw_en   = 1'b1;
                mw_addr = r_bidx;
                mw_data = ONES;
                n_bidx  = r_bidx + 1'b1;
            end
            ST_FINISH: begin
                mw_en       = 1'b1;
                n_whole     = CW'(r_set_count) > CW'(r_prof_thresh);
                n_widx      = '0;
                n_base      = '0;
                n_run_len   = '0;
                n_set_count = '0;
                n_run_sw    = '0;
                n_run_sb    = '0;
                n_eidx      = '0;
                n_ebase     = '0;
            end
            ST_EMIT_RD: begin
                mr_en   = 1'b1;
                mr_addr = r_eidx;
            end
            ST_EMIT_OUT: begin
                n_out_valid = 1'b1;
                n_out_word  = r_whole ? '0 : (r_row_rd & ~r_mask_rd & valid_mask);
                n_out_last  = emit_last;
                n_eidx      = r_eidx + 1'b1;
                n_ebase     = r_ebase + CW'(WORD_BITS);
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    // Control registers with synchronous reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_row_width   <= ROW_WIDTH_RST;
            r_run_thresh  <= RUN_THRESH_RST;
            r_prof_thresh <= PROF_THRESH_RST;
            r_widx        <= '0;
            r_base        <= '0;
            r_k           <= '0;
            r_run_len     <= '0;
            r_set_count   <= '0;
            r_final       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_widx      <= n_widx;
            r_base      <= n_base;
            r_k         <= n_k;
            r_run_len   <= n_run_len;
            r_set_count <= n_set_count;
            r_final     <= n_final;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_ROW_WIDTH:   r_row_width   <= pwdata[CFG_W-1:0];
                    REG_RUN_THRESH:  r_run_thresh  <= pwdata[CFG_W-1:0];
                    REG_PROF_THRESH: r_prof_thresh <= pwdata[CFG_W-1:0];
                    default: begin
                        r_row_width <= r_row_width;
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_word     <= n_word;
        r_cur_mask <= n_cur_mask;
        r_run_sw   <= n_run_sw;
        r_run_sb   <= n_run_sb;
        r_bidx     <= n_bidx;
        r_eidx     <= n_eidx;
        r_ebase    <= n_ebase;
        r_whole    <= n_whole;
        r_out_word <= n_out_word;
        r_out_last <= n_out_last;
    end

    // Row memory: written on each request, read during emission.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_row_mem[r_widx] <= i_pixel_word;
        end
        if (r_state == ST_EMIT_RD) begin
            r_row_rd <= r_row_mem[r_eidx];
        end
    end

    // Clear-mask memory: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (mw_en) begin
            r_mask_mem[mw_addr] <= mw_data;
        end
        if (mr_en) begin
            r_mask_rd <= r_mask_mem[mr_addr];
        end
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_cleaned_word = r_out_word;
    assign o_last_of_row  = r_out_last;

endmodule

>>> hdl/rrlr_checker.sv
`include "row_run_line_removal_unit_defines.svh"

module rrlr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_result_valid,
    input logic o_last_of_row
);

    // An accepted request keeps the block busy in the next cycle.
    `RRLR_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "request not taken")

    // Results never come in back-to-back cycles.
    `RRLR_ASSERT_NEXT(a_result_gap, i_clk, i_rst_n, o_result_valid, !o_result_valid, "results back to back")

    // Only the final word of a row may appear once the block is free.
    `RRLR_ASSERT_SAME(a_mid_row_busy, i_clk, i_rst_n, o_result_valid && !o_last_of_row, busy, "mid-row result while idle")

    // Every result follows a busy cycle.
    `RRLR_ASSERT_SAME(a_result_after_busy, i_clk, i_rst_n, o_result_valid, $past(busy), "result without work")

endmodule

bind row_run_line_removal_unit rrlr_checker u_rrlr_checker (.*);

>>> sim/row_run_line_removal_unit_test.sv
module row_run_line_removal_unit_test;
    import rrlr_pkg::*;

    localparam int WORD_BITS      = 32;
    localparam int MAX_ROW_PIXELS = 2048;
    localparam int ROW_WORDS      = MAX_ROW_PIXELS / WORD_BITS;
    localparam int SETTLE_CYCLES  = 160;
    localparam int RANDOM_WORDS   = 260;
    localparam int CALM_WORDS     = 40;
    localparam int REPORT_LIMIT   = 10;

    // One word of a cleaned row as it leaves the block.
    typedef struct packed {
        logic [WORD_BITS-1:0] pixels;
        logic                 last;
    } t_cleaned_word;

    // Tracks the row being received and queues the cleaned words it must produce.
    class t_line_removal_scoreboard;
        logic [WORD_BITS-1:0] row_store [ROW_WORDS];
        logic [WORD_BITS-1:0] clear_mask [ROW_WORDS];
        logic [5:0]           word_index;
        logic [11:0]          run_length;
        logic [11:0]          set_count;
        logic [10:0]          run_start;
        logic [CFG_W-1:0]     row_width;
        logic [CFG_W-1:0]     run_thresh;
        logic [CFG_W-1:0]     prof_thresh;
        t_cleaned_word        cleaned_due[$];
        int                   mismatch_count;

        function new();
            foreach (row_store[i]) begin
                row_store[i]  = '0;
                clear_mask[i] = '0;
            end
            word_index     = '0;
            run_length     = '0;
            set_count      = '0;
            run_start      = '0;
            row_width      = ROW_WIDTH_RST;
            run_thresh     = RUN_THRESH_RST;
            prof_thresh    = PROF_THRESH_RST;
            mismatch_count = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_ROW_WIDTH: row_width = value;
                REG_RUN_THRESH: run_thresh = value;
                REG_PROF_THRESH: prof_thresh = value;
                default: ;
            endcase
        endfunction

        // A zero width counts as one pixel, and wide settings saturate.
        function int unsigned active_width();
            if (row_width == 0) return 1;
            if (row_width > MAX_ROW_PIXELS) return MAX_ROW_PIXELS;
            return row_width;
        endfunction

        // A finished run longer than the threshold is marked for clearing.
        function void close_run();
            int c;
            if (run_length > run_thresh) begin
                for (c = int'(run_start);
                     c < int'(run_start) + int'(run_length) && c < MAX_ROW_PIXELS; c++)
                    clear_mask[c / WORD_BITS][c % WORD_BITS] = 1'b1;
            end
            run_length = '0;
        endfunction

        // Take one accepted word; at the row end, queue the whole cleaned row.
        function void note_word(logic [WORD_BITS-1:0] pixels);
            int unsigned          width;
            int unsigned          nwords;
            int unsigned          col;
            int unsigned          left;
            int                   w;
            int                   k;
            int                   n;
            logic                 whole;
            logic [WORD_BITS-1:0] valid;
            t_cleaned_word        res;
            width  = active_width();
            nwords = (width + WORD_BITS - 1) / WORD_BITS;
            w      = int'(word_index);
            row_store[w]  = pixels;
            clear_mask[w] = '0;
            for (k = 0; k < WORD_BITS; k++) begin
                col = w * WORD_BITS + k;
                if (col >= width) break;
                if (pixels[k]) begin
                    if (set_count != SET_COUNT_MAX) set_count++;
                    if (run_length == 0) run_start = 11'(col);
                    run_length++;
                end else begin
                    close_run();
                end
            end
            if (w + 1 < nwords) begin
                word_index = 6'(w + 1);
                return;
            end
            close_run();
            whole = set_count > prof_thresh;
            for (n = 0; n < nwords; n++) begin
                left = width - n * WORD_BITS;
                valid = (left >= WORD_BITS) ? '1 : ((32'd1 << left) - 32'd1);
                res.pixels = whole ? '0 : (row_store[n] & ~clear_mask[n] & valid);
                res.last   = (n + 1 == nwords);
                cleaned_due.insert(cleaned_due.size(), res);
            end
            word_index = '0;
            run_length = '0;
            set_count  = '0;
            run_start  = '0;
        endfunction

        function void flag(string what, logic [31:0] exp_v, logic [31:0] act_v);
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("mismatch in %s: expected %h, got %h", what, exp_v, act_v);
        endfunction

        // Compare one result with the oldest cleaned word still due.
        function void check_result(logic [WORD_BITS-1:0] pixels, logic last);
            t_cleaned_word due;
            if (cleaned_due.size() == 0) begin
                flag("result with none due", '0, pixels);
                return;
            end
            due = cleaned_due.pop_front();
            if (pixels !== due.pixels) flag("cleaned word", due.pixels, pixels);
            if (last !== due.last) flag("last of row", 32'(due.last), 32'(last));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [WORD_BITS-1:0]  i_pixel_word = '0;
    logic                  o_result_valid;
    logic [WORD_BITS-1:0]  o_cleaned_word;
    logic                  o_last_of_row;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    t_line_removal_scoreboard board;
    logic [WORD_BITS-1:0]   row_words [ROW_WORDS];
    int                     words_sent = 0;
    int                     wide_rows = 0;

    row_run_line_removal_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_pixel_word   (i_pixel_word),
        .o_result_valid (o_result_valid),
        .o_cleaned_word (o_cleaned_word),
        .o_last_of_row  (o_last_of_row),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #2 i_clk = ~i_clk;

    // Every strobed result is checked at the edge that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) board.check_result(o_cleaned_word, o_last_of_row);
    end

    // Present one word as a request and hold it until the block takes it.
    task automatic send_word(logic [WORD_BITS-1:0] pixels);
        @(negedge i_clk);
        start        <= 1'b1;
        i_pixel_word <= pixels;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_word(pixels);
        words_sent++;
    endtask

    task automatic idle_sender(int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Hold off until every cleaned word has come and the block is quiet again.
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (board.cleaned_due.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register, then read it back.
    task automatic set_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        board.write_reg(idx, value);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== APB_DATA_W'(value)) board.flag("register readback", value, prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(logic [CFG_W-1:0] width, logic [CFG_W-1:0] run_thr,
                             logic [CFG_W-1:0] prof_thr);
        settle();
        set_reg(REG_ROW_WIDTH, width);
        set_reg(REG_RUN_THRESH, run_thr);
        set_reg(REG_PROF_THRESH, prof_thr);
    endtask

    function automatic int clamp_width(int value);
        if (value == 0) return 1;
        if (value > MAX_ROW_PIXELS) return MAX_ROW_PIXELS;
        return value;
    endfunction

    // Mostly narrow rows; a few wide ones and the odd zero or saturating width.
    function automatic int pick_width();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r == 1 && wide_rows < 3) begin
            wide_rows++;
            return $urandom_range(MAX_ROW_PIXELS, 4095);
        end
        if (r <= 4) return $urandom_range(33, 640);
        return $urandom_range(1, 160);
    endfunction

    // Usually the host setting for the fraction, sometimes an extreme or any value.
    function automatic int pick_thresh(int width, int percent);
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return (clamp_width(width) * percent) / 100;
        if (r == 7) return $urandom_range(0, 4095);
        if (r == 8) return 0;
        return 4095;
    endfunction

    // Fill the row buffer: lines over light noise, or denser textures, solid ones or solid zeros.
    task automatic fill_row(int width, int run_thr);
        int style;
        int lines;
        int first;
        int span;
        int c;
        style = $urandom_range(0, 9);
        foreach (row_words[i]) begin
            case (style)
                5: row_words[i] = $urandom | $urandom;
                6: row_words[i] = $urandom;
                7: row_words[i] = '1;
                8: row_words[i] = '0;
                9: row_words[i] = $urandom_range(0, 1) ? '1 : ($urandom & $urandom);
                default: row_words[i] = $urandom & $urandom & $urandom;
            endcase
        end
        if (style > 4) return;
        lines = $urandom_range(1, 2);
        repeat (lines) begin
            first = $urandom_range(0, clamp_width(width) - 1);
            if (run_thr >= MAX_ROW_PIXELS) span = $urandom_range(1, clamp_width(width));
            else span = run_thr + $urandom_range(0, 4) - 2;
            if (span < 1) span = 1;
            for (c = first; c < first + span && c < MAX_ROW_PIXELS; c++)
                row_words[c / WORD_BITS][c % WORD_BITS] = 1'b1;
            // Bound the line so its length is exact.
            if (first > 0) row_words[(first - 1) / WORD_BITS][(first - 1) % WORD_BITS] = 1'b0;
            c = first + span;
            if (c < MAX_ROW_PIXELS) row_words[c / WORD_BITS][c % WORD_BITS] = 1'b0;
        end
    endtask

    initial begin
        int width;
        int run_thr;
        int prof_thr;
        int target;
        int shift_at;
        int i;
        bit gappy;
        bit first_row;

        board = new();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero width is one pixel; everything past it reads back as zero.
        configure(0, 4095, 4095);
        send_word('1);
        // A run threshold of zero clears every single pixel.
        configure(0, 0, 4095);
        send_word('1);
        send_word('0);
        // A run that reaches the row end is closed and cleared too.
        configure(32, 31, 4095);
        send_word('1);
        // A line across a word boundary, exactly at and just past the threshold.
        configure(40, 8, 4095);
        send_word(32'hF000_0000);
        send_word(32'hFFFF_FF0F);
        configure(40, 7, 4095);
        send_word(32'hF000_0000);
        send_word(32'hFFFF_FF0F);
        // The profile test clears the full row, column zero included.
        configure(32, 4095, 15);
        send_word(32'hAAAA_5555);
        send_word(32'h0000_7FFF);
        // Width shrunk in the middle of a row ends it at once.
        configure(96, 4095, 4095);
        send_word(32'h0000_FFFF);
        send_word(32'hFFFF_0000);
        settle();
        set_reg(REG_ROW_WIDTH, 32);
        send_word(32'h1234_5678);
        // Width grown in the middle of a row stretches it.
        configure(64, 4095, 4095);
        send_word('1);
        settle();
        set_reg(REG_ROW_WIDTH, 100);
        send_word(32'h8000_0001);
        send_word('0);
        send_word('1);

        // Random rows; the first one at a saturating width, its thresholds picked as for the rest.
        target = words_sent + RANDOM_WORDS;
        first_row = 1'b1;
        while (words_sent < target) begin
            if (first_row) begin
                wide_rows++;
                width    = 4095;
                run_thr  = pick_thresh(width, 65);
                prof_thr = pick_thresh(width, 80);
                configure(width, run_thr, prof_thr);
                first_row = 1'b0;
            end else if ($urandom_range(0, 2) == 0) begin
                width    = pick_width();
                run_thr  = pick_thresh(width, 65);
                prof_thr = pick_thresh(width, 80);
                configure(width, run_thr, prof_thr);
            end
            fill_row(board.active_width(), board.run_thresh);
            gappy = (words_sent < target - CALM_WORDS) && $urandom_range(0, 1);
            shift_at = -1;
            if (board.active_width() > WORD_BITS && $urandom_range(0, 19) == 0)
                shift_at = $urandom_range(1, (board.active_width() - 1) / WORD_BITS);
            i = 0;
            do begin
                if (i == shift_at) begin
                    settle();
                    set_reg(REG_ROW_WIDTH, $urandom_range(1, 320));
                end
                if (gappy && $urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 16));
                send_word(row_words[i]);
                i++;
            end while (board.word_index != 0);
        end

        // Drain the last row, then leave room for any stray result.
        @(negedge i_clk);
        start <= 1'b0;
        while (board.cleaned_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (board.mismatch_count == 0) begin
            $display("row_run_line_removal_unit verification clean");
        end else begin
            $display("row_run_line_removal_unit verification failed");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2400000;
        $display("row_run_line_removal_unit verification failed");
        $finish;
    end

endmodule
